// ===== sv/spf_pkg.sv =====
package spf_pkg;

    localparam int DEF_BLOCK_ENTRIES = 1024;
    localparam int DEF_ALLOW_ENTRIES = 256;
    localparam int DEF_SEARCH_WINDOW = 64;
    localparam int DEF_MIN_PAYLOAD   = 20;
    localparam int DEF_NUM_QUEUES    = 64;

    localparam logic [15:0] SIP_PORT_RESET = 16'd5060;
    localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;

    localparam logic [2:0] CMD_FRAME        = 3'd0;
    localparam logic [2:0] CMD_ADD_BLOCK    = 3'd1;
    localparam logic [2:0] CMD_REMOVE_BLOCK = 3'd2;
    localparam logic [2:0] CMD_ADD_ALLOW    = 3'd3;
    localparam logic [2:0] CMD_REMOVE_ALLOW = 3'd4;
    localparam logic [2:0] CMD_READ_COUNTER = 3'd5;

    localparam logic [1:0] VERDICT_PASS     = 2'd0;
    localparam logic [1:0] VERDICT_DROP     = 2'd1;
    localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

    localparam logic [2:0] REASON_NOT_SIP    = 3'd0;
    localparam logic [2:0] REASON_BLOCKED    = 3'd1;
    localparam logic [2:0] REASON_OPTIONS    = 3'd2;
    localparam logic [2:0] REASON_MALFORMED  = 3'd3;
    localparam logic [2:0] REASON_REDIRECTED = 3'd4;
    localparam logic [2:0] REASON_PASSED     = 3'd5;

    localparam logic [1:0] TSTAT_DONE   = 2'd0;
    localparam logic [1:0] TSTAT_FULL   = 2'd1;
    localparam logic [1:0] TSTAT_ABSENT = 2'd2;

    localparam int CNT_OPTIONS    = 0;
    localparam int CNT_REDIRECTED = 1;
    localparam int CNT_PASSED     = 2;
    localparam int CNT_BLOCKED    = 3;
    localparam int CNT_MALFORMED  = 4;
    localparam int NUM_COUNTERS   = 5;

    localparam logic ADDR_QUEUE_MASK = 1'b0;
    localparam logic ADDR_SIP_PORT   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FRAME_CHK,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_RM_RD,
        ST_RM_WR,
        ST_RESULT
    } spf_state_t;

    typedef enum logic [2:0] {
        RK_NOT_SIP,
        RK_BLOCKED,
        RK_OPT_DROP,
        RK_FINAL,
        RK_TBL_DONE,
        RK_TBL_FULL,
        RK_TBL_ABSENT,
        RK_COUNTER
    } spf_kind_t;

    typedef struct packed {
        logic      accept;
        logic      parse;
        logic      scan_start;
        logic      sel_load;
        logic      sel_allow;
        logic      scan_read;
        logic      scan_next;
        logic      append;
        logic      rm_read;
        logic      rm_write;
        logic      load_result;
        spf_kind_t kind;
    } spf_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       last;
        logic       hdr_ok;
        logic       short_payload;
        logic       opt_seen;
        logic       sel_allow;
        logic       hit;
        logic       scan_end;
        logic       full;
        logic       out_free;
    } spf_status_t;

endpackage

// ===== sv/spf_ram.sv =====
module spf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== sv/spf_ctrl.sv =====
module spf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  spf_pkg::spf_status_t sts,
    output spf_pkg::spf_cmd_t   ctl
);
    import spf_pkg::*;

    spf_state_t state_reg, state_next;
    spf_kind_t  kind_reg, kind_next;
    logic       is_add;
    logic       is_tbl;

    assign is_add = (sts.cmd == CMD_ADD_BLOCK) || (sts.cmd == CMD_ADD_ALLOW);
    assign is_tbl = (sts.cmd == CMD_ADD_BLOCK) || (sts.cmd == CMD_REMOVE_BLOCK) ||
                    (sts.cmd == CMD_ADD_ALLOW) || (sts.cmd == CMD_REMOVE_ALLOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= RK_NOT_SIP;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.cmd == CMD_FRAME)
                begin
                    state_next = sts.last ? ST_FRAME_CHK : ST_IDLE;
                end
                else if (is_tbl)
                begin
                    state_next = ST_SCAN_RD;
                end
                else if (sts.cmd == CMD_READ_COUNTER)
                begin
                    state_next = ST_RESULT;
                    kind_next  = RK_COUNTER;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FRAME_CHK:
            begin
                if (sts.hdr_ok)
                begin
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_RESULT;
                    kind_next  = RK_NOT_SIP;
                end
            end
            ST_SCAN_RD:
            begin
                if (!sts.scan_end)
                begin
                    state_next = ST_SCAN_CMP;
                end
                else if (sts.cmd == CMD_FRAME)
                begin
                    if (sts.sel_allow)
                    begin
                        state_next = ST_RESULT;
                        kind_next  = RK_OPT_DROP;
                    end
                    else if (sts.short_payload)
                    begin
                        state_next = ST_RESULT;
                        kind_next  = RK_NOT_SIP;
                    end
                    else if (sts.opt_seen)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                        kind_next  = RK_FINAL;
                    end
                end
                else if (is_add)
                begin
                    state_next = ST_RESULT;
                    kind_next  = sts.full ? RK_TBL_FULL : RK_TBL_DONE;
                end
                else
                begin
                    state_next = ST_RESULT;
                    kind_next  = RK_TBL_ABSENT;
                end
            end
            ST_SCAN_CMP:
            begin
                if (!sts.hit)
                begin
                    state_next = ST_SCAN_RD;
                end
                else if (sts.cmd == CMD_FRAME)
                begin
                    state_next = ST_RESULT;
                    kind_next  = sts.sel_allow ? RK_FINAL : RK_BLOCKED;
                end
                else if (is_add)
                begin
                    state_next = ST_RESULT;
                    kind_next  = RK_TBL_DONE;
                end
                else
                begin
                    state_next = ST_RM_RD;
                end
            end
            ST_RM_RD:
            begin
                state_next = ST_RM_WR;
            end
            ST_RM_WR:
            begin
                state_next = ST_RESULT;
                kind_next  = RK_TBL_DONE;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctl      = '0;
        ctl.kind = kind_reg;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                ctl.accept = in_valid;
            end
            ST_DECODE:
            begin
                ctl.parse      = (sts.cmd == CMD_FRAME);
                ctl.scan_start = is_tbl;
                ctl.sel_load   = is_tbl;
                ctl.sel_allow  = (sts.cmd == CMD_ADD_ALLOW) ||
                                 (sts.cmd == CMD_REMOVE_ALLOW);
            end
            ST_FRAME_CHK:
            begin
                ctl.scan_start = 1'b1;
                ctl.sel_load   = 1'b1;
                ctl.sel_allow  = 1'b0;
            end
            ST_SCAN_RD:
            begin
                ctl.scan_read = !sts.scan_end;
                if (sts.scan_end && sts.cmd == CMD_FRAME && !sts.sel_allow &&
                    !sts.short_payload && sts.opt_seen)
                begin
                    ctl.scan_start = 1'b1;
                    ctl.sel_load   = 1'b1;
                    ctl.sel_allow  = 1'b1;
                end
                ctl.append = sts.scan_end && is_add && !sts.full;
            end
            ST_SCAN_CMP:
            begin
                ctl.scan_next = !sts.hit;
            end
            ST_RM_RD:
            begin
                ctl.rm_read = 1'b1;
            end
            ST_RM_WR:
            begin
                ctl.rm_write = 1'b1;
            end
            ST_RESULT:
            begin
                ctl.load_result = sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

// ===== sv/spf_datapath.sv =====
module spf_datapath #(
    parameter int BLOCK_ENTRIES = spf_pkg::DEF_BLOCK_ENTRIES,
    parameter int ALLOW_ENTRIES = spf_pkg::DEF_ALLOW_ENTRIES,
    parameter int SEARCH_WINDOW = spf_pkg::DEF_SEARCH_WINDOW,
    parameter int MIN_PAYLOAD   = spf_pkg::DEF_MIN_PAYLOAD,
    parameter int NUM_QUEUES    = spf_pkg::DEF_NUM_QUEUES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spf_pkg::spf_cmd_t    ctl,
    output spf_pkg::spf_status_t sts,
    input  logic [2:0]           cmd,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [5:0]           queue_id,
    input  logic [31:0]          address_key,
    input  logic [2:0]           counter_index,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           verdict,
    output logic [2:0]           reason,
    output logic [5:0]           redirect_queue,
    output logic [1:0]           table_status,
    output logic [63:0]          counter_value
);
    import spf_pkg::*;

    localparam int BAW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
    localparam int AAW = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;
    localparam int BCW = $clog2(BLOCK_ENTRIES + 1);
    localparam int ACW = $clog2(ALLOW_ENTRIES + 1);
    localparam int IW  = (BCW > ACW) ? BCW : ACW;
    localparam logic [9:0] WIN_LAST = 10'(SEARCH_WINDOW - 8);
    localparam logic [9:0] MIN_PAY  = 10'(MIN_PAYLOAD);
    localparam logic [6:0] NQ       = 7'(NUM_QUEUES);

    // config
    logic [63:0] qmask_reg;
    logic [15:0] sip_port_reg;

    // item
    logic [2:0]  cmd_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [5:0]  qid_reg;
    logic [31:0] key_reg;
    logic [2:0]  cidx_reg;

    // frame parse state
    logic [7:0]  off_reg, off_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [2:0]  chk_reg, chk_next;
    logic [31:0] src_reg, src_next;
    logic [47:0] recent_reg, recent_next;
    logic        opt_reg, opt_next;
    logic        found_reg, found_next;

    // frame snapshot at last byte
    logic        hdr_ok_reg, hdr_ok_next;
    logic        short_reg, short_next;
    logic        snap_opt_reg;
    logic        snap_found_reg;
    logic [31:0] snap_src_reg;

    // tables
    logic [BCW-1:0] bcnt_reg;
    logic [ACW-1:0] acnt_reg;
    logic [IW-1:0]  idx_reg;
    logic           sel_allow_reg;
    logic [31:0]    brdata, ardata, rdata, lookup_key;
    logic           b_we, a_we;
    logic [BAW-1:0] b_waddr, b_raddr;
    logic [AAW-1:0] a_waddr, a_raddr;
    logic [31:0]    wdata;
    logic [IW-1:0]  cnt_ext;

    logic [63:0] ctr_reg [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] ctr_inc;

    logic        out_valid_reg;
    logic [1:0]  verdict_reg;
    logic [2:0]  reason_reg;
    logic [5:0]  rq_reg;
    logic [1:0]  tstat_reg;
    logic [63:0] cval_reg;
    logic        out_free;
    logic        bound;

    logic [9:0]  idx10, d10, p10, len10;
    logic [7:0]  b;

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qmask_reg    <= '0;
            sip_port_reg <= SIP_PORT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3] == ADDR_QUEUE_MASK)
            begin
                qmask_reg <= pwdata;
            end
            else
            begin
                sip_port_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[3] == ADDR_SIP_PORT) ? {48'd0, sip_port_reg} : qmask_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= cmd;
            byte_reg <= data_byte;
            last_reg <= last_byte;
            qid_reg  <= queue_id;
            key_reg  <= address_key;
            cidx_reg <= counter_index;
        end
    end

    // byte parser
    assign b     = byte_reg;
    assign idx10 = {2'b00, off_reg};
    assign d10   = 10'd14 + {4'd0, ihl_reg, 2'b00};
    assign p10   = d10 + 10'd8;
    assign len10 = idx10 + 10'd1;

    always_comb
    begin
        off_next    = off_reg;
        ihl_next    = ihl_reg;
        chk_next    = chk_reg;
        src_next    = src_reg;
        opt_next    = opt_reg;
        found_next  = found_reg;
        recent_next = {recent_reg[39:0], b};
        if (off_reg != 8'd255)
        begin
            if (off_reg == 8'd13 && {recent_reg[7:0], b} == ETH_TYPE_IPV4)
            begin
                chk_next[0] = 1'b1;
            end
            if (off_reg == 8'd14)
            begin
                ihl_next = b[3:0];
            end
            if (off_reg == 8'd23 && b == IP_PROTO_UDP)
            begin
                chk_next[1] = 1'b1;
            end
            if (off_reg >= 8'd26 && off_reg <= 8'd29)
            begin
                src_next = {src_reg[23:0], b};
            end
            if (idx10 == d10 + 10'd3 && {recent_reg[7:0], b} == sip_port_reg)
            begin
                chk_next[2] = 1'b1;
            end
            if (idx10 == p10 + 10'd2 && recent_reg[15:8] == "O" &&
                recent_reg[7:0] == "P" && b == "T")
            begin
                opt_next = 1'b1;
            end
            if (idx10 >= p10 + 10'd6 && (idx10 - p10 - 10'd6) <= WIN_LAST &&
                recent_reg[47:40] == "S" && recent_reg[39:32] == "I" &&
                recent_reg[31:24] == "P" && recent_reg[23:16] == "/" &&
                recent_reg[15:8] == "2" && recent_reg[7:0] == "." && b == "0")
            begin
                found_next = 1'b1;
            end
            off_next = off_reg + 8'd1;
        end
        hdr_ok_next = (len10 >= 10'd34) && (&chk_next) && (len10 >= p10);
        short_next  = len10 < p10 + MIN_PAY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= '0;
            ihl_reg    <= '0;
            chk_reg    <= '0;
            src_reg    <= '0;
            recent_reg <= '0;
            opt_reg    <= 1'b0;
            found_reg  <= 1'b0;
        end
        else if (ctl.parse)
        begin
            if (last_reg)
            begin
                off_reg    <= '0;
                ihl_reg    <= '0;
                chk_reg    <= '0;
                src_reg    <= '0;
                recent_reg <= '0;
                opt_reg    <= 1'b0;
                found_reg  <= 1'b0;
            end
            else
            begin
                off_reg    <= off_next;
                ihl_reg    <= ihl_next;
                chk_reg    <= chk_next;
                src_reg    <= src_next;
                recent_reg <= recent_next;
                opt_reg    <= opt_next;
                found_reg  <= found_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.parse && last_reg)
        begin
            hdr_ok_reg     <= hdr_ok_next;
            short_reg      <= short_next;
            snap_opt_reg   <= opt_next;
            snap_found_reg <= found_next;
            snap_src_reg   <= src_next;
        end
    end

    // table scan
    assign lookup_key = (cmd_reg == CMD_FRAME) ? snap_src_reg : key_reg;
    assign rdata      = sel_allow_reg ? ardata : brdata;
    assign cnt_ext    = sel_allow_reg ? IW'(acnt_reg) : IW'(bcnt_reg);
    assign wdata      = ctl.append ? lookup_key : rdata;

    always_comb
    begin
        b_raddr = idx_reg[BAW-1:0];
        a_raddr = idx_reg[AAW-1:0];
        if (ctl.rm_read)
        begin
            b_raddr = BAW'(bcnt_reg - BCW'(1));
            a_raddr = AAW'(acnt_reg - ACW'(1));
        end
        b_waddr = ctl.append ? BAW'(bcnt_reg) : idx_reg[BAW-1:0];
        a_waddr = ctl.append ? AAW'(acnt_reg) : idx_reg[AAW-1:0];
        b_we    = (ctl.append || ctl.rm_write) && !sel_allow_reg;
        a_we    = (ctl.append || ctl.rm_write) && sel_allow_reg;
    end

    spf_ram #(.WIDTH(32), .DEPTH(BLOCK_ENTRIES)) u_block_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (brdata)
    );

    spf_ram #(.WIDTH(32), .DEPTH(ALLOW_ENTRIES)) u_allow_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (ardata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg      <= '0;
            acnt_reg      <= '0;
            idx_reg       <= '0;
            sel_allow_reg <= 1'b0;
        end
        else
        begin
            if (ctl.sel_load)
            begin
                sel_allow_reg <= ctl.sel_allow;
            end
            if (ctl.scan_start)
            begin
                idx_reg <= '0;
            end
            else if (ctl.scan_next)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (ctl.append)
            begin
                if (sel_allow_reg)
                begin
                    acnt_reg <= acnt_reg + ACW'(1);
                end
                else
                begin
                    bcnt_reg <= bcnt_reg + BCW'(1);
                end
            end
            else if (ctl.rm_write)
            begin
                if (sel_allow_reg)
                begin
                    acnt_reg <= acnt_reg - ACW'(1);
                end
                else
                begin
                    bcnt_reg <= bcnt_reg - BCW'(1);
                end
            end
        end
    end

    // result
    assign out_free = !out_valid_reg || !out_stall;
    assign bound    = ({1'b0, qid_reg} < NQ) && qmask_reg[qid_reg];

    always_comb
    begin
        ctr_inc = '0;
        if (ctl.load_result)
        begin
            case (ctl.kind)
                RK_BLOCKED:  ctr_inc[CNT_BLOCKED] = 1'b1;
                RK_OPT_DROP: ctr_inc[CNT_OPTIONS] = 1'b1;
                RK_FINAL:
                begin
                    if (!snap_found_reg)
                    begin
                        ctr_inc[CNT_MALFORMED] = 1'b1;
                    end
                    else if (bound)
                    begin
                        ctr_inc[CNT_REDIRECTED] = 1'b1;
                    end
                    else
                    begin
                        ctr_inc[CNT_PASSED] = 1'b1;
                    end
                end
                default: ctr_inc = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                ctr_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                if (ctr_inc[i] && !(&ctr_reg[i]))
                begin
                    ctr_reg[i] <= ctr_reg[i] + 64'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_result)
        begin
            verdict_reg <= VERDICT_PASS;
            reason_reg  <= REASON_NOT_SIP;
            rq_reg      <= '0;
            tstat_reg   <= TSTAT_DONE;
            cval_reg    <= '0;
            case (ctl.kind)
                RK_NOT_SIP:
                begin
                    reason_reg <= REASON_NOT_SIP;
                end
                RK_BLOCKED:
                begin
                    verdict_reg <= VERDICT_DROP;
                    reason_reg  <= REASON_BLOCKED;
                end
                RK_OPT_DROP:
                begin
                    verdict_reg <= VERDICT_DROP;
                    reason_reg  <= REASON_OPTIONS;
                end
                RK_FINAL:
                begin
                    if (!snap_found_reg)
                    begin
                        verdict_reg <= VERDICT_DROP;
                        reason_reg  <= REASON_MALFORMED;
                    end
                    else if (bound)
                    begin
                        verdict_reg <= VERDICT_REDIRECT;
                        reason_reg  <= REASON_REDIRECTED;
                        rq_reg      <= qid_reg;
                    end
                    else
                    begin
                        reason_reg <= REASON_PASSED;
                    end
                end
                RK_TBL_FULL:   tstat_reg <= TSTAT_FULL;
                RK_TBL_ABSENT: tstat_reg <= TSTAT_ABSENT;
                RK_COUNTER:
                begin
                    case (cidx_reg)
                        3'd0:    cval_reg <= ctr_reg[0];
                        3'd1:    cval_reg <= ctr_reg[1];
                        3'd2:    cval_reg <= ctr_reg[2];
                        3'd3:    cval_reg <= ctr_reg[3];
                        3'd4:    cval_reg <= ctr_reg[4];
                        default: tstat_reg <= TSTAT_ABSENT;
                    endcase
                end
                default:
                begin
                    tstat_reg <= TSTAT_DONE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign reason         = reason_reg;
    assign redirect_queue = rq_reg;
    assign table_status   = tstat_reg;
    assign counter_value  = cval_reg;

    always_comb
    begin
        sts               = '0;
        sts.cmd           = cmd_reg;
        sts.last          = last_reg;
        sts.hdr_ok        = hdr_ok_reg;
        sts.short_payload = short_reg;
        sts.opt_seen      = snap_opt_reg;
        sts.sel_allow     = sel_allow_reg;
        sts.hit           = (rdata == lookup_key);
        sts.scan_end      = (idx_reg == cnt_ext);
        sts.full          = sel_allow_reg ? (acnt_reg == ACW'(ALLOW_ENTRIES))
                                          : (bcnt_reg == BCW'(BLOCK_ENTRIES));
        sts.out_free      = out_free;
    end

endmodule

// ===== sv/sip_packet_filter_core.sv =====
// sip packet filter: frame bytes (cmd 0) are taken one at a time, and in_stall
// holds off the next byte until the last one is done; the byte marked last is
// classified and gives one item on the output. the block and allow tables are
// memories with one read and one write port, kept packed with a fill count and
// searched one stored entry at a time; a last byte searches the block table,
// and the allow table as well when the payload starts with OPT; add and remove
// commands search the addressed table. no clearing pass runs after reset. a
// finished item waits in the output register while the next input item is
// taken.
module sip_packet_filter_core #(
    parameter int BLOCK_ENTRIES = spf_pkg::DEF_BLOCK_ENTRIES,
    parameter int ALLOW_ENTRIES = spf_pkg::DEF_ALLOW_ENTRIES,
    parameter int SEARCH_WINDOW = spf_pkg::DEF_SEARCH_WINDOW,
    parameter int MIN_PAYLOAD   = spf_pkg::DEF_MIN_PAYLOAD,
    parameter int NUM_QUEUES    = spf_pkg::DEF_NUM_QUEUES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [5:0]  queue_id,
    input  logic [31:0] address_key,
    input  logic [2:0]  counter_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    output logic [2:0]  reason,
    output logic [5:0]  redirect_queue,
    output logic [1:0]  table_status,
    output logic [63:0] counter_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import spf_pkg::*;

    spf_cmd_t    ctl;
    spf_status_t sts;

    assign pready = 1'b1;

    spf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    spf_datapath #(
        .BLOCK_ENTRIES (BLOCK_ENTRIES),
        .ALLOW_ENTRIES (ALLOW_ENTRIES),
        .SEARCH_WINDOW (SEARCH_WINDOW),
        .MIN_PAYLOAD   (MIN_PAYLOAD),
        .NUM_QUEUES    (NUM_QUEUES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .cmd            (cmd),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .queue_id       (queue_id),
        .address_key    (address_key),
        .counter_index  (counter_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict),
        .reason         (reason),
        .redirect_queue (redirect_queue),
        .table_status   (table_status),
        .counter_value  (counter_value)
    );

endmodule

// ===== sv/spf_checker.sv =====
module spf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  verdict,
    input logic [2:0]  reason,
    input logic [5:0]  redirect_queue,
    input logic [1:0]  table_status,
    input logic [63:0] counter_value
);
    import spf_pkg::*;

    // still busy in the cycle after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(reason) &&
        $stable(redirect_queue) && $stable(table_status) && $stable(counter_value))
        else $error("stalled output item changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict != VERDICT_REDIRECT |-> redirect_queue == '0)
        else $error("redirect queue set without redirect");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_status != TSTAT_DONE |->
        verdict == VERDICT_PASS && reason == REASON_NOT_SIP && counter_value == '0)
        else $error("frame fields set on failed command item");

endmodule

bind sip_packet_filter_core spf_checker u_spf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .verdict        (verdict),
    .reason         (reason),
    .redirect_queue (redirect_queue),
    .table_status   (table_status),
    .counter_value  (counter_value)
);

// ===== verif/tb_sip_packet_filter_core.sv =====
`timescale 1ns / 1ps

module tb_sip_packet_filter_core;
    import spf_pkg::*;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [5:0]  queue_id;
        logic [31:0] address_key;
        logic [2:0]  counter_index;
    } filter_item_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [2:0]  reason;
        logic [5:0]  redirect_queue;
        logic [1:0]  table_status;
        logic [63:0] counter_value;
    } verdict_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [5:0]  queue_id;
    logic [31:0] address_key;
    logic [2:0]  counter_index;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  verdict;
    logic [2:0]  reason;
    logic [5:0]  redirect_queue;
    logic [1:0]  table_status;
    logic [63:0] counter_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    sip_packet_filter_core dut (.*);

    filter_item_t  pending_items[$];
    verdict_item_t expected_verdicts[$];
    int            send_idle_pct;
    int            recv_idle_pct;
    int            mismatches;
    bit            stim_done;

    // shadow model state
    logic [63:0] m_queue_mask;
    logic [15:0] m_sip_port;
    int unsigned m_offset;
    logic [3:0]  m_ihl;
    logic [2:0]  m_checks;
    logic [31:0] m_src;
    logic [47:0] m_recent;
    bit          m_opt_seen;
    bit          m_sip_found;
    logic [31:0] m_block_keys[$];
    logic [31:0] m_allow_keys[$];
    logic [63:0] m_counters[NUM_COUNTERS];

    // host-side pool of candidate addresses, for stimulus choice
    logic [31:0] known_addrs[$];

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [7:0] recent_at(int back);
        return m_recent[8*back +: 8];
    endfunction

    function automatic bit key_present(ref logic [31:0] keys[$], input logic [31:0] key);
        foreach (keys[i])
            if (keys[i] == key)
                return 1;
        return 0;
    endfunction

    task automatic bump_counter(int c);
        if (m_counters[c] != {64{1'b1}})
            m_counters[c] = m_counters[c] + 1;
    endtask

    task automatic clear_frame_state();
        m_offset = 0;
        m_ihl = 0;
        m_checks = 0;
        m_src = 0;
        m_recent = 0;
        m_opt_seen = 0;
        m_sip_found = 0;
    endtask

    task automatic table_add(ref logic [31:0] keys[$], input int depth,
                             input logic [31:0] key, output logic [1:0] st);
        st = TSTAT_DONE;
        if (!key_present(keys, key))
        begin
            if (keys.size() >= depth)
                st = TSTAT_FULL;
            else
                keys.push_back(key);
        end
    endtask

    task automatic table_remove(ref logic [31:0] keys[$], input logic [31:0] key,
                                output logic [1:0] st);
        st = TSTAT_ABSENT;
        foreach (keys[i])
            if (keys[i] == key)
            begin
                keys.delete(i);
                st = TSTAT_DONE;
                break;
            end
    endtask

    task automatic predict_verdict(input filter_item_t it);
        verdict_item_t r;
        int unsigned   idx;
        int unsigned   d;
        int unsigned   p;
        int unsigned   len;
        logic [7:0]    b;
        logic [1:0]    st;
        r = '0;
        b = it.data_byte;
        if (it.cmd == CMD_FRAME)
        begin
            idx = m_offset;
            d = 14 + 4 * m_ihl;
            p = d + 8;
            if (idx < 255)
            begin
                if (idx == 13 && {recent_at(0), b} == ETH_TYPE_IPV4)
                    m_checks[0] = 1'b1;
                if (idx == 14)
                    m_ihl = b[3:0];
                if (idx == 23 && b == IP_PROTO_UDP)
                    m_checks[1] = 1'b1;
                if (idx >= 26 && idx <= 29)
                    m_src = {m_src[23:0], b};
                if (idx == d + 3 && {recent_at(0), b} == m_sip_port)
                    m_checks[2] = 1'b1;
                if (idx == p + 2 && recent_at(1) == "O" && recent_at(0) == "P" && b == "T")
                    m_opt_seen = 1;
                if (idx >= p + 6 && idx - 6 - p <= DEF_SEARCH_WINDOW - 8 &&
                    {m_recent, b} == "SIP/2.0")
                    m_sip_found = 1;
                m_offset = idx + 1;
            end
            m_recent = {m_recent[39:0], b};
            if (!it.last_byte)
                return;
            len = idx + 1;
            if (len < 14 || !m_checks[0] || len < 34 || !m_checks[1] ||
                len < p || !m_checks[2])
                r.reason = REASON_NOT_SIP;
            else if (key_present(m_block_keys, m_src))
            begin
                r.verdict = VERDICT_DROP;
                r.reason = REASON_BLOCKED;
                bump_counter(CNT_BLOCKED);
            end
            else if (len < p + DEF_MIN_PAYLOAD)
                r.reason = REASON_NOT_SIP;
            else if (m_opt_seen && !key_present(m_allow_keys, m_src))
            begin
                r.verdict = VERDICT_DROP;
                r.reason = REASON_OPTIONS;
                bump_counter(CNT_OPTIONS);
            end
            else if (!m_sip_found)
            begin
                r.verdict = VERDICT_DROP;
                r.reason = REASON_MALFORMED;
                bump_counter(CNT_MALFORMED);
            end
            else if (m_queue_mask[it.queue_id])
            begin
                r.verdict = VERDICT_REDIRECT;
                r.reason = REASON_REDIRECTED;
                r.redirect_queue = it.queue_id;
                bump_counter(CNT_REDIRECTED);
            end
            else
            begin
                r.reason = REASON_PASSED;
                bump_counter(CNT_PASSED);
            end
            clear_frame_state();
            expected_verdicts.push_back(r);
            return;
        end
        case (it.cmd)
            CMD_ADD_BLOCK:    table_add(m_block_keys, DEF_BLOCK_ENTRIES, it.address_key, st);
            CMD_REMOVE_BLOCK: table_remove(m_block_keys, it.address_key, st);
            CMD_ADD_ALLOW:    table_add(m_allow_keys, DEF_ALLOW_ENTRIES, it.address_key, st);
            CMD_REMOVE_ALLOW: table_remove(m_allow_keys, it.address_key, st);
            CMD_READ_COUNTER:
            begin
                st = TSTAT_DONE;
                if (it.counter_index < NUM_COUNTERS)
                    r.counter_value = m_counters[it.counter_index];
                else
                    st = TSTAT_ABSENT;
            end
            default:
                return;
        endcase
        r.table_status = st;
        expected_verdicts.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_verdict({cmd, data_byte, last_byte, queue_id, address_key,
                                 counter_index});
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    {cmd, data_byte, last_byte, queue_id, address_key, counter_index}
                        <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        verdict_item_t got;
        verdict_item_t exp_v;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {verdict, reason, redirect_queue, table_status, counter_value};
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: %p", got);
                end
                else
                begin
                    exp_v = expected_verdicts.pop_front();
                    if (got !== exp_v)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", exp_v, got);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic apb_write(input logic [3:0] addr, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 4'd0)
            m_queue_mask = value;
        else
            m_sip_port = value[15:0];
    endtask

    task automatic push_item(input logic [2:0] c, input logic [7:0] b, input logic l,
                             input logic [5:0] q, input logic [31:0] k,
                             input logic [2:0] ci);
        pending_items.push_back({c, b, l, q, k, ci});
    endtask

    task automatic push_table(input logic [2:0] c, input logic [31:0] k);
        push_item(c, $urandom, $urandom, $urandom, k, $urandom);
    endtask

    // kind: 0 good sip, 1 options, 2 no version, 3 no sip message,
    // 4 wrong port, 5 not ipv4, 6 not udp, 7 truncated, 8 random noise
    task automatic push_frame(input int kind, input logic [31:0] src, input int ihl,
                              input int pay_len, input logic [5:0] q);
        logic [7:0] fr[$];
        int         d;
        int         pos;
        string      msg;
        d = 14 + 4 * ihl;
        for (int i = 0; i < 12; i++)
            fr.push_back($urandom);
        fr.push_back(kind == 5 ? 8'h86 : 8'h08);
        fr.push_back(8'h00);
        fr.push_back({4'h4, ihl[3:0]});
        for (int i = 15; i < 34; i++)
            fr.push_back($urandom);
        fr[23] = (kind == 6) ? 8'd6 : IP_PROTO_UDP;
        for (int i = 0; i < 4; i++)
            fr[26 + i] = src[31 - 8*i -: 8];
        while (fr.size() < d + 8)
            fr.push_back($urandom);
        fr[d + 2] = m_sip_port[15:8];
        fr[d + 3] = (kind == 4) ? ~m_sip_port[7:0] : m_sip_port[7:0];
        msg = (kind == 1) ? "OPTIONS sip:a SIP/2.0" : "INVITE sip:b SIP/2.0";
        if (kind == 2)
            msg = "REGISTER sip:x SIP/1.0";
        for (int i = 0; i < pay_len; i++)
            fr.push_back($urandom_range(32, 126));
        if (kind != 3 && pay_len >= msg.len())
        begin
            pos = (kind == 1) ? 0 : $urandom_range(0, pay_len - msg.len() > 40 ? 40 :
                                                  pay_len - msg.len());
            for (int i = 0; i < msg.len(); i++)
                fr[d + 8 + pos + i] = msg[i];
        end
        if (kind == 7)
            fr = fr[0:$urandom_range(0, d + 6)];
        if (kind == 8)
            foreach (fr[i])
                fr[i] = $urandom;
        foreach (fr[i])
        begin
            if ($urandom_range(99) < 3)
                push_table($urandom_range(1, 5), known_addrs[$urandom_range(0,
                           known_addrs.size() - 1)]);
            push_item(CMD_FRAME, fr[i], i == fr.size() - 1, q, $urandom, $urandom);
        end
    endtask

    task automatic wait_drain();
        while (pending_items.size() > 0 || in_valid || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic random_phase(input int n_items);
        int start;
        int kind;
        start = 0;
        while (start < n_items)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 14)
            begin
                push_frame(kind < 6 ? 0 : kind < 9 ? 1 : kind < 10 ? 2 : kind < 11 ? 3 :
                           kind < 12 ? 4 : kind < 13 ? 7 : 8,
                           known_addrs[$urandom_range(0, known_addrs.size() - 1)],
                           $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : 5,
                           $urandom_range(0, 9) == 0 ? $urandom_range(0, 240) :
                           $urandom_range(18, 40),
                           $urandom);
                start += 60;
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    push_item($urandom_range(6, 7), $urandom, $urandom, $urandom,
                              $urandom, $urandom);
                else
                    push_table($urandom_range(1, 5), $urandom_range(0, 7) == 0 ? $urandom :
                               known_addrs[$urandom_range(0, known_addrs.size() - 1)]);
                start += 1;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {cmd, data_byte, last_byte, queue_id, address_key, counter_index} = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mismatches = 0;
        stim_done = 0;
        m_queue_mask = '0;
        m_sip_port = SIP_PORT_RESET;
        clear_frame_state();
        foreach (m_counters[i])
            m_counters[i] = '0;
        known_addrs = '{32'h0a000001, 32'hc0a80105, 32'hffffffff, 32'h00000000,
                        32'h7f000001, 32'hac100a0a};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        push_frame(0, 32'h0a000001, 5, 30, 6'd3);
        push_table(CMD_ADD_BLOCK, 32'h0a000001);
        push_table(CMD_ADD_BLOCK, 32'h0a000001);
        push_frame(0, 32'h0a000001, 5, 30, 6'd3);
        push_table(CMD_REMOVE_BLOCK, 32'h0a000001);
        push_table(CMD_REMOVE_BLOCK, 32'h0a000001);
        push_frame(1, 32'hc0a80105, 5, 30, 6'd0);
        push_table(CMD_ADD_ALLOW, 32'hc0a80105);
        push_frame(1, 32'hc0a80105, 5, 30, 6'd63);
        push_table(CMD_REMOVE_ALLOW, 32'hffffffff);
        push_frame(2, 32'h0, 5, 30, 6'd1);
        push_frame(3, 32'h0, 5, 10, 6'd1);
        push_frame(0, 32'h0, 0, 30, 6'd1);
        push_frame(0, 32'h0, 15, 250, 6'd2);
        push_frame(5, 32'h0, 5, 30, 6'd1);
        push_frame(6, 32'h0, 5, 30, 6'd1);
        push_frame(7, 32'h0, 5, 30, 6'd1);
        for (int i = 0; i < 8; i++)
            push_item(CMD_READ_COUNTER, 8'hff, 1'b1, 6'h3f, 32'hffffffff, i);
        push_item(3'd7, 8'h00, 1'b0, 6'h00, 32'h0, 3'd0);
        wait_drain();

        apb_write(4'd0, 64'hffffffff_ffffffff);
        push_frame(0, 32'h7f000001, 5, 30, 6'd63);
        push_frame(0, 32'h7f000001, 5, 30, 6'd0);
        wait_drain();

        send_idle_pct = 9;
        recv_idle_pct = 70;
        apb_write(4'd0, {$urandom, $urandom});
        random_phase(400);
        wait_drain();

        send_idle_pct = 70;
        recv_idle_pct = 9;
        apb_write(4'd8, 64'd0);
        apb_write(4'd0, {$urandom, $urandom});
        random_phase(300);
        wait_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apb_write(4'd8, 64'hffff);
        apb_write(4'd0, 64'd0);
        random_phase(450);
        for (int i = 0; i < NUM_COUNTERS; i++)
            push_table(CMD_READ_COUNTER, 32'h0);
        wait_drain();
        apb_write(4'd8, {$urandom, $urandom});
        random_phase(100);
        wait_drain();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
